// ----- src/rae_pkg.sv -----
// Shared definitions for the register ALU / load executor.
// Field widths, stream packing, action and opcode codes, and default sizes.
// No dependencies.
`default_nettype none

package rae_pkg;

    // payload field widths
    localparam int ACT_W     = 2;
    localparam int OP_W      = 3;
    localparam int IDX_W     = 3;
    localparam int PV_W      = 32;
    localparam int OUT_W     = 32;

    // stream bus widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    // default sizes
    localparam int REGISTER_COUNT_DEF = 8;
    localparam int MEMORY_WORDS_DEF   = 8;
    localparam int DATA_WIDTH_DEF     = 32;

    // action codes
    localparam logic [ACT_W-1:0] ACT_EXEC     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_REG = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOAD_MEM = 2'd2;

    // opcodes
    localparam logic [OP_W-1:0] OP_ADD = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB = 3'd2;
    localparam logic [OP_W-1:0] OP_AND = 3'd3;
    localparam logic [OP_W-1:0] OP_OR  = 3'd4;
    localparam logic [OP_W-1:0] OP_LD  = 3'd5;

    // register file write request
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } rf_wr_t;

endpackage

`default_nettype wire

// ----- src/rae_regfile.sv -----
// Register file: two registered read ports with write-first bypass, one write port.
// Entries read as zero until first written (per-entry valid bits). Uses rae_pkg.
`default_nettype none

module rae_regfile
    import rae_pkg::*;
#(
    parameter int REGISTER_COUNT = REGISTER_COUNT_DEF,
    parameter int DATA_WIDTH     = DATA_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  rd_en,
    input  wire logic [IDX_W-1:0]      rd_idx_a,
    input  wire logic [IDX_W-1:0]      rd_idx_b,
    output logic      [DATA_WIDTH-1:0] rd_data_a,
    output logic      [DATA_WIDTH-1:0] rd_data_b,
    input  wire rf_wr_t                wr,
    input  wire logic [DATA_WIDTH-1:0] wr_data
);

    localparam int RAW = $clog2(REGISTER_COUNT);

    logic [DATA_WIDTH-1:0]     regs [REGISTER_COUNT];
    logic [REGISTER_COUNT-1:0] valid_reg;
    logic [DATA_WIDTH-1:0]     rd_a_reg;
    logic [DATA_WIDTH-1:0]     rd_b_reg;

    logic           a_in, b_in, w_in;
    logic           a_hit, b_hit;
    logic [RAW-1:0] a_addr, b_addr, w_addr;

    assign a_addr = RAW'(rd_idx_a);
    assign b_addr = RAW'(rd_idx_b);
    assign w_addr = RAW'(wr.idx);
    assign a_in   = 32'(rd_idx_a) < REGISTER_COUNT;
    assign b_in   = 32'(rd_idx_b) < REGISTER_COUNT;
    assign w_in   = wr.en && (32'(wr.idx) < REGISTER_COUNT);
    assign a_hit  = w_in && (wr.idx == rd_idx_a);
    assign b_hit  = w_in && (wr.idx == rd_idx_b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (w_in) begin
            valid_reg[w_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (w_in) begin
            regs[w_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (!a_in) begin
                rd_a_reg <= '0;
            end else if (a_hit) begin
                rd_a_reg <= wr_data;
            end else if (valid_reg[a_addr]) begin
                rd_a_reg <= regs[a_addr];
            end else begin
                rd_a_reg <= '0;
            end
            if (!b_in) begin
                rd_b_reg <= '0;
            end else if (b_hit) begin
                rd_b_reg <= wr_data;
            end else if (valid_reg[b_addr]) begin
                rd_b_reg <= regs[b_addr];
            end else begin
                rd_b_reg <= '0;
            end
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

// ----- src/rae_dmem.sv -----
// Data memory: one write port, one registered read port, zeroed by a sweep after reset.
// busy is high during the sweep. Uses rae_pkg for default sizes.
`default_nettype none

module rae_dmem
    import rae_pkg::*;
#(
    parameter int MEMORY_WORDS = MEMORY_WORDS_DEF,
    parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
    parameter int MAW          = $clog2(MEMORY_WORDS)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    output logic                       busy,
    input  wire logic                  wr_en,
    input  wire logic [MAW-1:0]        wr_addr,
    input  wire logic [DATA_WIDTH-1:0] wr_data,
    input  wire logic                  rd_en,
    input  wire logic [MAW-1:0]        rd_addr,
    output logic      [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [MEMORY_WORDS];
    logic                  clr_busy_reg;
    logic [MAW-1:0]        clr_addr_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            if (clr_addr_reg == MAW'(MEMORY_WORDS - 1)) begin
                clr_busy_reg <= 1'b0;
            end else begin
                clr_addr_reg <= clr_addr_reg + MAW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign busy    = clr_busy_reg;
    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- src/register_alu_load_executor_top.sv -----
// Register ALU / load executor: three-stage pipeline, one word per cycle sustained while
// m_tready is high and the data memory is not busy. Stages in order: operands read at
// the accepting edge, ALU + data memory read, output register; stalls on m_tready
// back up stage by stage.
// Reset (aresetn, synchronous, active low) empties the pipeline and zeroes the register
// file at once; the data memory is zeroed by a sweep over all MEMORY_WORDS words with s_tready low.
// Uses rae_pkg, rae_regfile and rae_dmem.
`default_nettype none

module register_alu_load_executor_top
    import rae_pkg::*;
#(
    parameter int REGISTER_COUNT = REGISTER_COUNT_DEF,
    parameter int MEMORY_WORDS   = MEMORY_WORDS_DEF,
    parameter int DATA_WIDTH     = DATA_WIDTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // op_code[2:0], target_index[5:3], src_a_index[8:6], src_b_index[11:9],
    // preload_value[43:12], zero fill[47:44]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // action[1:0]
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    input  wire logic                 s_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // written_index[2:0], written_value[34:3], zero fill[39:35]
    output logic      [M_TDATA_W-1:0] m_tdata,
    // wrote_register[0], address_error[1]
    output logic      [M_TUSER_W-1:0] m_tuser,
    output logic                      m_tlast
);

    localparam int DW  = DATA_WIDTH;
    localparam int MAW = $clog2(MEMORY_WORDS);

    // ---------------- handshake ----------------
    logic s_accept;
    logic mem_busy;
    logic out_free, e2_ready, e1_ready;

    // ---------------- stage 1 ----------------
    logic              e1_valid_reg;
    logic [ACT_W-1:0]  e1_act_reg;
    logic [OP_W-1:0]   e1_op_reg;
    logic [IDX_W-1:0]  e1_dst_reg, e1_src_a_reg, e1_src_b_reg;
    logic [PV_W-1:0]   e1_pv_reg;
    logic              e1_last_reg;
    logic [DW-1:0]     rf_rd_a, rf_rd_b;

    // ---------------- stage 2 ----------------
    logic              e2_valid_reg;
    logic              e2_wr_reg, e2_load_reg, e2_err_reg, e2_last_reg;
    logic [IDX_W-1:0]  e2_dst_reg;
    logic [DW-1:0]     e2_value_reg;
    logic [DW-1:0]     mem_rd_data;
    logic [DW-1:0]     e2_wval;

    // ---------------- output ----------------
    logic              m_tvalid_reg, m_wrote_reg, m_err_reg, m_last_reg;
    logic [IDX_W-1:0]  m_idx_reg;
    logic [OUT_W-1:0]  m_val_reg;
    logic [OUT_W-1:0]  out_val;

    assign out_free = !m_tvalid_reg || m_tready;
    assign e2_ready = !e2_valid_reg || out_free;
    assign e1_ready = !e1_valid_reg || e2_ready;
    assign s_tready = e1_ready && !mem_busy;
    assign s_accept = s_tvalid && s_tready;

    // register file write happens as the stage 2 word moves to the output
    rf_wr_t rf_wr;
    assign rf_wr.en  = e2_valid_reg && out_free && e2_wr_reg;
    assign rf_wr.idx = e2_dst_reg;

    rae_regfile #(
        .REGISTER_COUNT (REGISTER_COUNT),
        .DATA_WIDTH     (DW)
    ) u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (s_accept),
        .rd_idx_a  (s_tdata[8:6]),
        .rd_idx_b  (s_tdata[11:9]),
        .rd_data_a (rf_rd_a),
        .rd_data_b (rf_rd_b),
        .wr        (rf_wr),
        .wr_data   (e2_wval)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_valid_reg <= 1'b0;
        end else if (e1_ready) begin
            e1_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            e1_act_reg   <= s_tuser[1:0];
            e1_op_reg    <= s_tdata[2:0];
            e1_dst_reg   <= s_tdata[5:3];
            e1_src_a_reg <= s_tdata[8:6];
            e1_src_b_reg <= s_tdata[11:9];
            e1_pv_reg    <= s_tdata[43:12];
            e1_last_reg  <= s_tlast;
        end
    end

    // ---------------- stage 1 execute ----------------
    logic [DW-1:0]  opa, opb, sum, diff, pv_ext;
    logic           addr_ok, dst_ok, mdst_ok;
    logic           wr_raw, mem_we, mem_re;
    logic           e1_go;
    logic           e2_wr_next, e2_load_next, e2_err_next;
    logic [DW-1:0]  e2_value_next;

    // words still in stage 2 have not reached the register file yet
    assign e2_wval = e2_load_reg ? mem_rd_data : e2_value_reg;
    assign opa = (e2_valid_reg && e2_wr_reg && e2_dst_reg == e1_src_a_reg) ? e2_wval : rf_rd_a;
    assign opb = (e2_valid_reg && e2_wr_reg && e2_dst_reg == e1_src_b_reg) ? e2_wval : rf_rd_b;

    assign sum     = opa + opb;
    assign diff    = opa - opb;
    assign addr_ok = 64'(sum) < 64'(MEMORY_WORDS);
    assign dst_ok  = 32'(e1_dst_reg) < REGISTER_COUNT;
    assign mdst_ok = 32'(e1_dst_reg) < MEMORY_WORDS;

    generate
        if (DW >= PV_W) begin : g_pv_wide
            assign pv_ext = {{(DW - PV_W){e1_pv_reg[PV_W-1]}}, e1_pv_reg};
        end else begin : g_pv_narrow
            assign pv_ext = e1_pv_reg[DW-1:0];
        end
    endgenerate

    always_comb begin
        wr_raw        = 1'b0;
        e2_load_next  = 1'b0;
        e2_err_next   = 1'b0;
        mem_we        = 1'b0;
        e2_value_next = '0;
        unique case (e1_act_reg)
            ACT_EXEC: begin
                unique case (e1_op_reg)
                    OP_ADD: begin
                        wr_raw        = 1'b1;
                        e2_value_next = sum;
                    end
                    OP_SUB: begin
                        wr_raw        = 1'b1;
                        e2_value_next = diff;
                    end
                    OP_AND: begin
                        wr_raw        = 1'b1;
                        e2_value_next = DW'(opa != '0 && opb != '0);
                    end
                    OP_OR: begin
                        wr_raw        = 1'b1;
                        e2_value_next = DW'(opa != '0 || opb != '0);
                    end
                    OP_LD: begin
                        if (addr_ok) begin
                            wr_raw       = 1'b1;
                            e2_load_next = 1'b1;
                        end else begin
                            e2_err_next  = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ACT_LOAD_REG: begin
                wr_raw        = 1'b1;
                e2_value_next = pv_ext;
            end
            ACT_LOAD_MEM: begin
                mem_we = mdst_ok;
            end
            default: ;
        endcase
    end

    assign e2_wr_next = wr_raw && dst_ok;
    assign e1_go      = e1_valid_reg && e2_ready;
    assign mem_re     = e1_go && e2_load_next;

    rae_dmem #(
        .MEMORY_WORDS (MEMORY_WORDS),
        .DATA_WIDTH   (DW),
        .MAW          (MAW)
    ) u_dmem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .busy    (mem_busy),
        .wr_en   (e1_go && mem_we),
        .wr_addr (MAW'(e1_dst_reg)),
        .wr_data (pv_ext),
        .rd_en   (mem_re),
        .rd_addr (MAW'(sum)),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e2_valid_reg <= 1'b0;
        end else if (e2_ready) begin
            e2_valid_reg <= e1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (e1_go) begin
            e2_wr_reg    <= e2_wr_next;
            e2_load_reg  <= e2_load_next;
            e2_err_reg   <= e2_err_next;
            e2_dst_reg   <= e1_dst_reg;
            e2_value_reg <= e2_value_next;
            e2_last_reg  <= e1_last_reg;
        end
    end

    // ---------------- output register ----------------
    generate
        if (DW >= OUT_W) begin : g_out_wide
            assign out_val = e2_wval[OUT_W-1:0];
        end else begin : g_out_narrow
            assign out_val = {{(OUT_W - DW){e2_wval[DW-1]}}, e2_wval};
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= e2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && e2_valid_reg) begin
            m_wrote_reg <= e2_wr_reg;
            m_idx_reg   <= e2_wr_reg ? e2_dst_reg : '0;
            m_val_reg   <= e2_wr_reg ? out_val : '0;
            m_err_reg   <= e2_err_reg;
            m_last_reg  <= e2_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - OUT_W - IDX_W){1'b0}}, m_val_reg, m_idx_reg};
    assign m_tuser  = {m_err_reg, m_wrote_reg};
    assign m_tlast  = m_last_reg;

    // ---------------- assertions ----------------
    a_write_or_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("result word reports both a register write and an address error");

    a_quiet_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("index or value nonzero on a word without a register write");

    a_no_accept_clear: assert property (@(posedge aclk)
        mem_busy |-> !s_tready)
        else $error("input accepted during data memory clear");

    a_stage1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (e1_valid_reg && !e2_ready) |=> e1_valid_reg)
        else $error("stage 1 word dropped while stage 2 stalled");

endmodule

`default_nettype wire
